// File: rtl/core/sparse_table_range_query_top_assert.svh
// Assertion macros for the sparse table range query block
`ifndef SPARSE_TABLE_RANGE_QUERY_TOP_ASSERT_SVH
`define SPARSE_TABLE_RANGE_QUERY_TOP_ASSERT_SVH

// same-cycle implication
`define STQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/stq_pkg.sv
// Shared types and constants for the sparse table range query block
package stq_pkg;

    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 11;
    localparam int LOG_W   = 4;

    typedef enum logic [1:0] {
        MODE_MIN = 2'd0,
        MODE_MAX = 2'd1,
        MODE_AND = 2'd2,
        MODE_OR  = 2'd3
    } combine_mode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_RANGE    = 2'd1,
        STATUS_NO_TABLE = 2'd2
    } status_t;

endpackage

// File: rtl/core/stq_combine.sv
// Shared combine unit: signed min, signed max, bitwise and, bitwise or
module stq_combine #(
    parameter int DATA_WIDTH = 32
) (
    input  stq_pkg::combine_mode_t        mode,
    input  logic signed [DATA_WIDTH-1:0]  a,
    input  logic signed [DATA_WIDTH-1:0]  b,
    output logic signed [DATA_WIDTH-1:0]  y
);

    always_comb
    begin
        unique case (mode)
            stq_pkg::MODE_MIN: y = (b < a) ? b : a;
            stq_pkg::MODE_MAX: y = (a < b) ? b : a;
            stq_pkg::MODE_AND: y = a & b;
            stq_pkg::MODE_OR:  y = a | b;
        endcase
    end

endmodule

// File: rtl/core/stq_level_mem.sv
// Level store: one write port, two registered read ports
module stq_level_mem #(
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_W     = 14,
    parameter int DEPTH      = 11264
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [ADDR_W-1:0]             waddr,
    input  logic signed [DATA_WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0]             raddr_a,
    input  logic [ADDR_W-1:0]             raddr_b,
    output logic signed [DATA_WIDTH-1:0]  rdata_a,
    output logic signed [DATA_WIDTH-1:0]  rdata_b
);

    logic signed [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: rtl/core/sparse_table_range_query_top.sv
// Sparse table range query engine: load, build and query sequencer
// Load: accepted while idle, no result. A load marked last starts the build:
//   per level a check, then per entry a read of the pair, then combine and write.
// Query: S_Q_LEN, S_Q_LOG, S_Q_READ, then S_Q_OUT registers the result (an error goes
//   straight to S_Q_OUT) and waits while out_stall. Input stalled during a build or query.
// Reset (async, active low) clears count, built flag, mode and output valid.
module sparse_table_range_query_top #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int LEVELS       = 11,
    parameter int DATA_WIDTH   = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [1:0]                            cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  action,
    input  logic signed [stq_pkg::VALUE_W-1:0]    element_value,
    input  logic                                  last_element,
    input  logic [stq_pkg::INDEX_W-1:0]           range_left,
    input  logic [stq_pkg::INDEX_W-1:0]           range_right,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [stq_pkg::VALUE_W-1:0]    range_result,
    output logic [1:0]                            query_status
);

    `include "sparse_table_range_query_top_assert.svh"

    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W  = $clog2(MAX_ELEMENTS);
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int J_W    = $clog2(LEVELS + 1);
    localparam int SW     = CNT_W + 1;
    localparam int ADDR_W = LVL_W + IDX_W;
    localparam int DEPTH  = LEVELS * (2 ** IDX_W);
    localparam int CMP_W  = CNT_W + stq_pkg::INDEX_W;
    localparam int LEN_W  = stq_pkg::LEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_B_LEVEL,
        S_B_READ,
        S_B_WRITE,
        S_Q_LEN,
        S_Q_LOG,
        S_Q_READ,
        S_Q_OUT
    } state_t;

    function automatic logic [stq_pkg::LOG_W-1:0] floor_log2(input logic [LEN_W-1:0] x);
        logic [stq_pkg::LOG_W-1:0] r;
        r = '0;
        for (int k = 1; k < LEN_W; k++)
        begin
            if (x[k])
            begin
                r = stq_pkg::LOG_W'(k);
            end
        end
        return r;
    endfunction

    state_t                          state_reg,        state_next;
    logic [CNT_W-1:0]                count_reg,        count_next;
    logic                            built_reg,        built_next;
    stq_pkg::combine_mode_t          mode_reg,         mode_next;
    stq_pkg::combine_mode_t          built_mode_reg,   built_mode_next;
    logic [J_W-1:0]                  j_reg,            j_next;
    logic [SW-1:0]                   step_reg,         step_next;
    logic [CNT_W-1:0]                i_reg,            i_next;
    logic [stq_pkg::INDEX_W-1:0]     left_reg,         left_next;
    logic [stq_pkg::INDEX_W-1:0]     right_reg,        right_next;
    logic [LEN_W-1:0]                len_reg,          len_next;
    logic [LVL_W-1:0]                qj_reg,           qj_next;
    stq_pkg::status_t                err_reg,          err_next;
    logic                            out_valid_reg,    out_valid_next;
    logic signed [stq_pkg::VALUE_W-1:0] result_reg,    result_next;
    stq_pkg::status_t                status_reg,       status_next;

    logic                            in_accept;
    logic                            out_free;
    logic [CNT_W-1:0]                load_base;
    logic                            load_fits;
    logic [stq_pkg::LOG_W-1:0]       len_log;

    logic                            mem_we;
    logic [ADDR_W-1:0]               mem_waddr;
    logic signed [DATA_WIDTH-1:0]    mem_wdata;
    logic [ADDR_W-1:0]               mem_raddr_a;
    logic [ADDR_W-1:0]               mem_raddr_b;
    logic signed [DATA_WIDTH-1:0]    mem_rdata_a;
    logic signed [DATA_WIDTH-1:0]    mem_rdata_b;
    logic signed [DATA_WIDTH-1:0]    comb_y;

    logic [LEN_W-1:0]                q_idx_b;
    logic [SW-1:0]                   b_sum;

    assign in_stall     = (state_reg != S_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign range_result = result_reg;
    assign query_status = status_reg;

    assign load_base = built_reg ? '0 : count_reg;
    assign load_fits = (load_base < CNT_W'(MAX_ELEMENTS));
    assign len_log   = floor_log2(len_reg);
    assign q_idx_b   = LEN_W'(right_reg) + LEN_W'(1) - (LEN_W'(1) << qj_reg);
    assign b_sum     = SW'(i_reg) + step_reg;

    stq_level_mem #(
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W),
        .DEPTH      (DEPTH)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    stq_combine #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_combine (
        .mode (built_mode_reg),
        .a    (mem_rdata_a),
        .b    (mem_rdata_b),
        .y    (comb_y)
    );

    always_comb
    begin
        if (state_reg == S_B_WRITE)
        begin
            mem_we    = 1'b1;
            mem_waddr = {LVL_W'(j_reg), IDX_W'(i_reg)};
            mem_wdata = comb_y;
        end
        else
        begin
            mem_we    = in_accept && !action && load_fits;
            mem_waddr = {LVL_W'(0), IDX_W'(load_base)};
            mem_wdata = DATA_WIDTH'(element_value);
        end

        // query addresses held through S_Q_OUT so the pair stays valid under out_stall
        if ((state_reg == S_Q_READ) || (state_reg == S_Q_OUT))
        begin
            mem_raddr_a = {qj_reg, IDX_W'(left_reg)};
            mem_raddr_b = {qj_reg, IDX_W'(q_idx_b)};
        end
        else
        begin
            mem_raddr_a = {LVL_W'(j_reg - J_W'(1)), IDX_W'(i_reg)};
            mem_raddr_b = {LVL_W'(j_reg - J_W'(1)), IDX_W'(b_sum)};
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        built_next      = built_reg;
        mode_next       = mode_reg;
        built_mode_next = built_mode_reg;
        j_next          = j_reg;
        step_next       = step_reg;
        i_next          = i_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        len_next        = len_reg;
        qj_next         = qj_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg && out_stall;
        result_next     = result_reg;
        status_next     = status_reg;

        if (cfg_we)
        begin
            mode_next = stq_pkg::combine_mode_t'(cfg_wdata);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (!action)
                    begin
                        built_next = 1'b0;
                        count_next = load_fits ? load_base + CNT_W'(1) : load_base;
                        if (last_element)
                        begin
                            built_mode_next = mode_reg;
                            j_next          = J_W'(1);
                            step_next       = SW'(1);
                            state_next      = S_B_LEVEL;
                        end
                    end
                    else
                    begin
                        left_next  = range_left;
                        right_next = range_right;
                        if (!built_reg)
                        begin
                            err_next   = stq_pkg::STATUS_NO_TABLE;
                            state_next = S_Q_OUT;
                        end
                        else if ((range_left > range_right) ||
                                 (CMP_W'(range_right) >= CMP_W'(count_reg)))
                        begin
                            err_next   = stq_pkg::STATUS_RANGE;
                            state_next = S_Q_OUT;
                        end
                        else
                        begin
                            err_next   = stq_pkg::STATUS_OK;
                            state_next = S_Q_LEN;
                        end
                    end
                end
            end
            S_B_LEVEL:
            begin
                if ((j_reg == J_W'(LEVELS)) || (step_reg >= SW'(count_reg)))
                begin
                    built_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = '0;
                    state_next = S_B_READ;
                end
            end
            S_B_READ:
            begin
                state_next = S_B_WRITE;
            end
            S_B_WRITE:
            begin
                i_next = i_reg + CNT_W'(1);
                if ((b_sum + SW'(1)) < SW'(count_reg))
                begin
                    state_next = S_B_READ;
                end
                else
                begin
                    j_next     = j_reg + J_W'(1);
                    step_next  = step_reg << 1;
                    state_next = S_B_LEVEL;
                end
            end
            S_Q_LEN:
            begin
                len_next   = LEN_W'(right_reg) - LEN_W'(left_reg) + LEN_W'(1);
                state_next = S_Q_LOG;
            end
            S_Q_LOG:
            begin
                if (int'(len_log) > LEVELS - 1)
                begin
                    qj_next = LVL_W'(LEVELS - 1);
                end
                else
                begin
                    qj_next = LVL_W'(len_log);
                end
                state_next = S_Q_READ;
            end
            S_Q_READ:
            begin
                state_next = S_Q_OUT;
            end
            S_Q_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = err_reg;
                    result_next    = (err_reg == stq_pkg::STATUS_OK)
                                   ? stq_pkg::VALUE_W'(comb_y) : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            built_reg      <= 1'b0;
            mode_reg       <= stq_pkg::MODE_MIN;
            built_mode_reg <= stq_pkg::MODE_MIN;
            j_reg          <= '0;
            step_reg       <= '0;
            i_reg          <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            len_reg        <= '0;
            qj_reg         <= '0;
            err_reg        <= stq_pkg::STATUS_OK;
            out_valid_reg  <= 1'b0;
            result_reg     <= '0;
            status_reg     <= stq_pkg::STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            built_reg      <= built_next;
            mode_reg       <= mode_next;
            built_mode_reg <= built_mode_next;
            j_reg          <= j_next;
            step_reg       <= step_next;
            i_reg          <= i_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            len_reg        <= len_next;
            qj_reg         <= qj_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
            result_reg     <= result_next;
            status_reg     <= status_next;
        end
    end

    `STQ_ASSERT_SAME(a_result_from_query, clk, rst_n,
        $rose(out_valid_reg), $past(state_reg) == S_Q_OUT,
        "result appeared without a query")
    `STQ_ASSERT_SAME(a_build_keeps_level0, clk, rst_n,
        state_reg == S_B_WRITE, j_reg != J_W'(0) && mem_we,
        "build write aimed at level 0")
    `STQ_ASSERT_SAME(a_build_nonempty, clk, rst_n,
        state_reg == S_B_LEVEL, count_reg != '0 && !built_reg,
        "build running on empty or built table")

endmodule

// File: dv/tb_sparse_table_range_query_top.sv
`timescale 1ns / 1ps
// Testbench for the sparse table range query engine: loads, table builds and range queries
module tb_sparse_table_range_query_top;

    localparam int  TABLE_DEPTH  = 1024;
    localparam int  TABLE_LEVELS = 11;
    localparam int  CYCLE_LIMIT  = 1_200_000;
    localparam int  HOLD_CYCLES  = 300;
    localparam bit  ACT_LOAD     = 1'b0;
    localparam bit  ACT_QUERY    = 1'b1;

    typedef struct packed {
        logic signed [stq_pkg::VALUE_W-1:0] value;
        stq_pkg::status_t                   status;
    } answer_t;

    logic                                clk;
    logic                                rst_n         = 1'b0;
    logic                                cfg_we        = 1'b0;
    logic [1:0]                          cfg_wdata     = stq_pkg::MODE_MIN;
    logic                                in_valid      = 1'b0;
    logic                                in_stall;
    logic                                action        = ACT_LOAD;
    logic signed [stq_pkg::VALUE_W-1:0]  element_value = '0;
    logic                                last_element  = 1'b0;
    logic [stq_pkg::INDEX_W-1:0]         range_left    = '0;
    logic [stq_pkg::INDEX_W-1:0]         range_right   = '0;
    logic                                out_valid;
    logic                                out_stall     = 1'b0;
    logic signed [stq_pkg::VALUE_W-1:0]  range_result;
    logic [1:0]                          query_status;

    logic signed [stq_pkg::VALUE_W-1:0]  loaded_values [TABLE_DEPTH];
    int unsigned                         loaded_count  = 0;
    bit                                  table_ready   = 1'b0;
    stq_pkg::combine_mode_t              mode_reg      = stq_pkg::MODE_MIN;
    stq_pkg::combine_mode_t              mode_latched  = stq_pkg::MODE_MIN;
    answer_t                             answers_due [$];

    int  sent_count      = 0;
    int  checked_count   = 0;
    int  build_count     = 0;
    int  ok_count        = 0;
    int  range_err_count = 0;
    int  no_table_count  = 0;
    int  fail_count      = 0;
    int  cycle_count     = 0;
    int  build_budget    = 0;
    int  hold_left       = 0;
    bit  hold_go         = 1'b0;
    bit  idle_on         = 1'b1;

    sparse_table_range_query_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .element_value (element_value),
        .last_element  (last_element),
        .range_left    (range_left),
        .range_right   (range_right),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .range_result  (range_result),
        .query_status  (query_status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic signed [stq_pkg::VALUE_W-1:0] merge_values(
        stq_pkg::combine_mode_t m,
        logic signed [stq_pkg::VALUE_W-1:0] a,
        logic signed [stq_pkg::VALUE_W-1:0] b);
        case (m)
            stq_pkg::MODE_MIN: return (b < a) ? b : a;
            stq_pkg::MODE_MAX: return (a < b) ? b : a;
            stq_pkg::MODE_AND: return a & b;
            default:           return a | b;
        endcase
    endfunction

    // Folds an accepted request into the table copy; queries scan the range directly.
    function automatic void fold_request(bit act, logic signed [stq_pkg::VALUE_W-1:0] val,
                                         bit last, logic [stq_pkg::INDEX_W-1:0] l,
                                         logic [stq_pkg::INDEX_W-1:0] r);
        answer_t                            ans;
        logic signed [stq_pkg::VALUE_W-1:0] acc;
        if (act == ACT_LOAD)
        begin
            if (table_ready)
            begin
                table_ready  = 1'b0;
                loaded_count = 0;
            end
            if (loaded_count < TABLE_DEPTH)
            begin
                loaded_values[loaded_count] = val;
                loaded_count++;
            end
            if (last)
            begin
                mode_latched = mode_reg;
                table_ready  = 1'b1;
                build_count++;
                build_budget = TABLE_LEVELS * (2 * loaded_count + 1) + 16;
            end
        end
        else
        begin
            ans.value = '0;
            if (!table_ready)
            begin
                ans.status = stq_pkg::STATUS_NO_TABLE;
                no_table_count++;
            end
            else if (l > r || r >= loaded_count)
            begin
                ans.status = stq_pkg::STATUS_RANGE;
                range_err_count++;
            end
            else
            begin
                acc = loaded_values[l];
                for (int i = l + 1; i <= r; i++)
                    acc = merge_values(mode_latched, acc, loaded_values[i]);
                ans.value  = acc;
                ans.status = stq_pkg::STATUS_OK;
                ok_count++;
            end
            answers_due.push_back(ans);
        end
    endfunction

    task automatic send_request(bit act, logic signed [stq_pkg::VALUE_W-1:0] val, bit last,
                                logic [stq_pkg::INDEX_W-1:0] l,
                                logic [stq_pkg::INDEX_W-1:0] r);
        while (idle_on && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        element_value <= val;
        last_element  <= last;
        range_left    <= l;
        range_right   <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        fold_request(act, val, last, l, r);
        sent_count++;
    endtask

    // Drain answers, then give any build in flight its worst-case time.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (build_budget + 8)
            @(posedge clk);
        build_budget = 0;
    endtask

    task automatic write_mode(stq_pkg::combine_mode_t m);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mode_reg   = m;
    endtask

    function automatic logic signed [stq_pkg::VALUE_W-1:0] draw_value(int style);
        if ($urandom_range(15) == 0)
        begin
            case ($urandom_range(3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return 32'sh0000_0000;
                default: return 32'shFFFF_FFFF;
            endcase
        end
        case (style)
            0:       return $urandom;
            1:       return int'($urandom_range(200)) - 100;
            2:       return $urandom | $urandom;
            default: return $urandom & $urandom & $urandom;
        endcase
    endfunction

    task automatic send_random_query();
        int kind;
        int l;
        int r;
        kind = $urandom_range(99);
        if (table_ready && kind < 75)
        begin
            l = $urandom_range(loaded_count - 1);
            if (kind < 35)
                r = (l + $urandom_range(3) < loaded_count) ? l + $urandom_range(3) : l;
            else
                r = $urandom_range(loaded_count - 1, l);
        end
        else if (kind < 85)
        begin
            l = $urandom_range(1023, 1);
            r = $urandom_range(l - 1);
        end
        else if (kind < 93 && loaded_count < TABLE_DEPTH)
        begin
            r = $urandom_range(1023, loaded_count);
            l = $urandom_range(r);
        end
        else
        begin
            l = $urandom_range(1023);
            r = $urandom_range(1023);
        end
        send_request(ACT_QUERY, $urandom, $urandom_range(1), l, r);
    endtask

    task automatic test_reset_state();
        send_request(ACT_QUERY, 32'sh0, 1'b0, 0, 0);
        send_request(ACT_QUERY, 32'shFFFF_FFFF, 1'b1, 1023, 1023);
    endtask

    task automatic test_directed_modes();
        // reset mode is min, no write yet
        send_request(ACT_LOAD, 32'sh7FFF_FFFF, 1'b0, 1023, 0);
        send_request(ACT_LOAD, 32'sh8000_0000, 1'b0, 0, 1023);
        send_request(ACT_LOAD, 32'sh0000_0000, 1'b0, 0, 0);
        send_request(ACT_LOAD, 32'shFFFF_FFFF, 1'b0, 0, 0);
        send_request(ACT_LOAD, 32'sh1234_5678, 1'b1, 0, 0);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 0, 4);
        send_request(ACT_QUERY, 32'sh0, 1'b1, 3, 4);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 2, 2);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 4, 0);
        send_request(ACT_QUERY, 32'sh0, 1'b1, 0, 5);
        // queries keep the mode latched at build
        write_mode(stq_pkg::MODE_MAX);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 0, 4);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 1, 3);
        send_request(ACT_LOAD, -32'sd5, 1'b1, 0, 0);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 0, 0);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 0, 1);
        write_mode(stq_pkg::MODE_AND);
        send_request(ACT_LOAD, 32'shF0F0_FFFF, 1'b0, 0, 0);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 0, 0);
        send_request(ACT_LOAD, 32'shFF00_F0F0, 1'b0, 0, 0);
        send_request(ACT_LOAD, 32'sh8F0F_0FF0, 1'b1, 0, 0);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 0, 2);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 1, 2);
        write_mode(stq_pkg::MODE_OR);
        send_request(ACT_LOAD, 32'sh0000_0001, 1'b0, 0, 0);
        send_request(ACT_LOAD, 32'sh8000_0000, 1'b0, 0, 0);
        send_request(ACT_LOAD, 32'sh0102_0000, 1'b1, 0, 0);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 0, 2);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 0, 1);
    endtask

    task automatic test_mode_latch();
        write_mode(stq_pkg::MODE_OR);
        send_request(ACT_LOAD, 32'sh0F0F_00FF, 1'b0, 0, 0);
        send_request(ACT_LOAD, 32'sh00FF_0F0F, 1'b0, 0, 0);
        write_mode(stq_pkg::MODE_AND);
        send_request(ACT_LOAD, 32'shFFFF_0FF0, 1'b1, 0, 0);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 0, 2);
        write_mode(stq_pkg::MODE_MIN);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 0, 2);
    endtask

    task automatic test_output_hold();
        write_mode(stq_pkg::combine_mode_t'($urandom_range(3)));
        for (int i = 0; i < 20; i++)
            send_request(ACT_LOAD, draw_value($urandom_range(3)), i == 19, 0, 0);
        hold_go = 1'b1;
        repeat (40)
            send_random_query();
    endtask

    task automatic test_random_sequences(int amount);
        int stop_at;
        int n;
        int style;
        stop_at = sent_count + amount;
        while (sent_count < stop_at)
        begin
            if ($urandom_range(3) == 0)
                write_mode(stq_pkg::combine_mode_t'($urandom_range(3)));
            n     = ($urandom_range(11) == 0) ? $urandom_range(300, 64) : $urandom_range(40, 1);
            style = $urandom_range(3);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(24) == 0)
                    send_random_query();
                send_request(ACT_LOAD, draw_value(style),
                             (i == n - 1) && ($urandom_range(9) != 0), $urandom, $urandom);
            end
            repeat ($urandom_range(24, 4))
                send_random_query();
        end
    endtask

    // Full array plus two dropped loads; the dropped last mark still builds.
    task automatic test_full_array();
        write_mode(stq_pkg::combine_mode_t'($urandom_range(3)));
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
            send_request(ACT_LOAD, draw_value(i % 4), i == TABLE_DEPTH + 1, $urandom, $urandom);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 0, 1023);
        send_request(ACT_QUERY, 32'sh0, 1'b1, 512, 1023);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 1023, 1023);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 0, 1022);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 513, 1000);
        send_request(ACT_QUERY, 32'sh0, 1'b0, 0, 511);
        repeat (14)
            send_random_query();
    endtask

    always @(posedge clk)
    begin
        if (hold_go)
        begin
            hold_left = HOLD_CYCLES;
            hold_go   = 1'b0;
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left  = hold_left - 1;
        end
        else
            out_stall <= idle_on && ($urandom_range(99) < 14);
    end

    always @(posedge clk)
    begin : check_answers
        answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (answers_due.size() == 0)
            begin
                $error("result with no query outstanding: range_result %h query_status %0d",
                       range_result, query_status);
                fail_count++;
            end
            else
            begin
                want = answers_due.pop_front();
                checked_count++;
                if (range_result !== want.value)
                begin
                    $error("range_result: expected %h, got %h", want.value, range_result);
                    fail_count++;
                end
                if (query_status !== want.status)
                begin
                    $error("query_status: expected %0d, got %0d", want.status, query_status);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("[sparse_table_range_query_top] ERROR");
        $finish;
    end

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_directed_modes();
        test_mode_latch();
        test_output_hold();
        idle_on = 1'b1;
        test_random_sequences(180);
        idle_on = 1'b0;
        test_random_sequences(150);
        idle_on = 1'b1;
        test_random_sequences(150);
        test_full_array();
        settle_block();
        repeat (20)
            @(posedge clk);
        if (answers_due.size() != 0)
        begin
            $error("%0d queries never answered", answers_due.size());
            fail_count++;
        end
        $display("coverage: %0d requests sent, %0d tables built, %0d answers checked",
                 sent_count, build_count, checked_count);
        $display("answers: %0d in range, %0d bad range, %0d before build",
                 ok_count, range_err_count, no_table_count);
        if (fail_count == 0)
            $display("[sparse_table_range_query_top] OK");
        else
            $display("[sparse_table_range_query_top] ERROR");
        $finish;
    end

endmodule
